[rtl/core/aarf_pkg.sv]
package aarf_pkg;

  // Fixed field widths of the item and result words, the settings and the table.
  localparam int STATION_W = 6;
  localparam int RATE_W    = 4;
  localparam int RETRY_W   = 4;
  localparam int RUN_W     = 8;
  localparam int TIMER_W   = 12;
  localparam int THR_W     = 8;
  localparam int GROWTH_W  = 8;

  // APB register map: register i sits at byte address 4*i.
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [2:0] {
    CFG_INIT_THR   = 3'd0,
    CFG_MAX_THR    = 3'd1,
    CFG_SPACING    = 3'd2,
    CFG_MIN_TIMER  = 3'd3,
    CFG_THR_GROWTH = 3'd4,
    CFG_TMR_GROWTH = 3'd5,
    CFG_START_RATE = 3'd6,
    CFG_TOP_RATE   = 3'd7
  } cfg_idx_t;

  // Command codes carried by the input word.
  localparam logic CMD_QUERY  = 1'b0;
  localparam logic CMD_REPORT = 1'b1;

  typedef struct packed {
    logic [THR_W-1:0]    init_thr;
    logic [THR_W-1:0]    max_thr;
    logic [RETRY_W-1:0]  spacing;
    logic [TIMER_W-1:0]  min_timer;
    logic [GROWTH_W-1:0] thr_growth;
    logic [GROWTH_W-1:0] tmr_growth;
    logic [RATE_W-1:0]   start_rate;
    logic [RATE_W-1:0]   top_rate;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    init_thr:   8'd10,
    max_thr:    8'd50,
    spacing:    4'd2,
    min_timer:  12'd15,
    thr_growth: 8'd32,
    tmr_growth: 8'd32,
    start_rate: 4'd0,
    top_rate:   4'd7
  };

  // Per-station state as stored in the station table.
  typedef struct packed {
    logic [RATE_W-1:0]  rate;
    logic [RUN_W-1:0]   run;
    logic [TIMER_W-1:0] timer;
    logic [THR_W-1:0]   thr;
    logic [TIMER_W-1:0] limit;
    logic               probe;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t e;
  } mem_word_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear;
    logic capture;
    logic read;
    logic eval;
    logic mul1;
    logic mul2;
    logic update;
    logic load_out;
  } cmd_t;

endpackage

[rtl/core/aarf_regs.sv]
module aarf_regs (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [aarf_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [aarf_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [aarf_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                pready,
  output aarf_pkg::cfg_t                      cfg
);

  aarf_pkg::cfg_t     cfg_r;
  aarf_pkg::cfg_idx_t idx;
  logic               wr_en;

  assign idx    = aarf_pkg::cfg_idx_t'(paddr[4:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= aarf_pkg::CFG_RESET;
    end else if (wr_en) begin
      case (idx)
        aarf_pkg::CFG_INIT_THR:   cfg_r.init_thr   <= pwdata[7:0];
        aarf_pkg::CFG_MAX_THR:    cfg_r.max_thr    <= pwdata[7:0];
        aarf_pkg::CFG_SPACING:    cfg_r.spacing    <= pwdata[3:0];
        aarf_pkg::CFG_MIN_TIMER:  cfg_r.min_timer  <= pwdata[11:0];
        aarf_pkg::CFG_THR_GROWTH: cfg_r.thr_growth <= pwdata[7:0];
        aarf_pkg::CFG_TMR_GROWTH: cfg_r.tmr_growth <= pwdata[7:0];
        aarf_pkg::CFG_START_RATE: cfg_r.start_rate <= pwdata[3:0];
        aarf_pkg::CFG_TOP_RATE:   cfg_r.top_rate   <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      aarf_pkg::CFG_INIT_THR:   prdata = 32'(cfg_r.init_thr);
      aarf_pkg::CFG_MAX_THR:    prdata = 32'(cfg_r.max_thr);
      aarf_pkg::CFG_SPACING:    prdata = 32'(cfg_r.spacing);
      aarf_pkg::CFG_MIN_TIMER:  prdata = 32'(cfg_r.min_timer);
      aarf_pkg::CFG_THR_GROWTH: prdata = 32'(cfg_r.thr_growth);
      aarf_pkg::CFG_TMR_GROWTH: prdata = 32'(cfg_r.tmr_growth);
      aarf_pkg::CFG_START_RATE: prdata = 32'(cfg_r.start_rate);
      aarf_pkg::CFG_TOP_RATE:   prdata = 32'(cfg_r.top_rate);
      default:                  prdata = '0;
    endcase
  end

endmodule

[rtl/core/aarf_ctrl.sv]
module aarf_ctrl #(
  parameter int STATIONS = 64,
  parameter int IDX_W    = 6
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output aarf_pkg::cmd_t   cmd,
  output logic [IDX_W-1:0] clr_addr
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_EVAL,
    S_MUL1,
    S_MUL2,
    S_UPDATE,
    S_FINISH
  } state_t;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(STATIONS - 1);

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] clr_cnt_r, clr_cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             slot_free;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign clr_addr  = clr_cnt_r;
  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    cmd          = '0;
    cmd.clear    = (state_r == S_CLEAR);
    cmd.capture  = (state_r == S_IDLE) && in_valid;
    cmd.read     = (state_r == S_READ);
    cmd.eval     = (state_r == S_EVAL);
    cmd.mul1     = (state_r == S_MUL1);
    cmd.mul2     = (state_r == S_MUL2);
    cmd.update   = (state_r == S_UPDATE);
    cmd.load_out = (state_r == S_FINISH) && slot_free;
  end

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    out_valid_nxt = out_ready ? 1'b0 : out_valid_r;
    case (state_r)
      S_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == LAST_IDX) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_READ;
        end
      end
      S_READ:   state_nxt = S_EVAL;
      S_EVAL:   state_nxt = S_MUL1;
      S_MUL1:   state_nxt = S_MUL2;
      S_MUL2:   state_nxt = S_UPDATE;
      S_UPDATE: state_nxt = S_FINISH;
      S_FINISH: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[rtl/core/aarf_dp.sv]
module aarf_dp #(
  parameter int STATIONS   = 64,
  parameter int RATE_COUNT = 16,
  parameter int IDX_W      = 6
) (
  input  logic                               clk,
  input  aarf_pkg::cmd_t                     cmd,
  input  logic [IDX_W-1:0]                   clr_addr,
  input  aarf_pkg::cfg_t                     cfg,
  input  logic                               in_command,
  input  logic [aarf_pkg::STATION_W-1:0]     in_station,
  input  logic                               in_success,
  input  logic [aarf_pkg::RETRY_W-1:0]       in_retry_count,
  output logic [aarf_pkg::RATE_W-1:0]        out_rate,
  output logic                               out_rate_changed,
  output logic                               out_probing
);

  localparam int STATION_CODES = 1 << aarf_pkg::STATION_W;
  localparam int RATE_CODE_MAX = (1 << aarf_pkg::RATE_W) - 1;
  localparam int RMAX_I = (RATE_COUNT - 1 > RATE_CODE_MAX) ? RATE_CODE_MAX : RATE_COUNT - 1;
  localparam logic [aarf_pkg::RATE_W-1:0] RMAX = aarf_pkg::RATE_W'(RMAX_I);
  localparam int PROD_W = aarf_pkg::THR_W + aarf_pkg::GROWTH_W;

  // Remainder of a retry count by a nonzero spacing, one restoring step per bit.
  function automatic logic [aarf_pkg::RETRY_W-1:0] rem_calc(
    input logic [aarf_pkg::RETRY_W-1:0] a,
    input logic [aarf_pkg::RETRY_W-1:0] d
  );
    logic [aarf_pkg::RETRY_W:0] r;
    r = '0;
    for (int i = aarf_pkg::RETRY_W - 1; i >= 0; i--) begin
      r = {r[aarf_pkg::RETRY_W-1:0], a[i]};
      if (r >= {1'b0, d}) begin
        r = r - {1'b0, d};
      end
    end
    return r[aarf_pkg::RETRY_W-1:0];
  endfunction

  // Station codes fold onto the table depth through a constant lookup.
  logic [IDX_W-1:0] wrap_tab [STATION_CODES];
  for (genvar g = 0; g < STATION_CODES; g++) begin : g_wrap
    assign wrap_tab[g] = IDX_W'(g % STATIONS);
  end

  aarf_pkg::mem_word_t mem [STATIONS];

  logic                             cmd_r;
  logic [IDX_W-1:0]                 idx_r;
  logic                             ok_r;
  logic [aarf_pkg::RETRY_W-1:0]     retries_r;
  aarf_pkg::mem_word_t              rd_word_r;
  aarf_pkg::entry_t                 e_r;
  logic                             new_r;
  logic                             rem_zero_r;
  logic [PROD_W-1:0]                prod1_r;
  logic [PROD_W-1:0]                prod2_r;
  logic [aarf_pkg::THR_W-1:0]       th_r;
  aarf_pkg::entry_t                 n_e;
  logic                             n_changed;
  aarf_pkg::entry_t                 res_e_r;
  logic                             res_changed_r;
  logic [aarf_pkg::RATE_W-1:0]      out_rate_r;
  logic                             out_changed_r;
  logic                             out_probe_r;

  logic [aarf_pkg::RATE_W-1:0]      top_c;
  logic [aarf_pkg::RATE_W-1:0]      start_c;
  logic [aarf_pkg::RETRY_W-1:0]     spacing_c;
  logic [PROD_W-aarf_pkg::GROWTH_W+3:0] th_raw;
  logic [aarf_pkg::THR_W-1:0]       th_c;
  logic [aarf_pkg::TIMER_W-1:0]     tl_raw;
  aarf_pkg::mem_word_t              wr_word;

  assign top_c     = (cfg.top_rate > RMAX) ? RMAX : cfg.top_rate;
  assign start_c   = (cfg.start_rate > RMAX) ? RMAX : cfg.start_rate;
  assign spacing_c = (cfg.spacing == '0) ? aarf_pkg::RETRY_W'(1) : cfg.spacing;

  // Floor of threshold * growth / 16, capped at the maximum threshold.
  assign th_raw = prod1_r[PROD_W-1:4];
  assign th_c   = (th_raw > (PROD_W-4)'(cfg.max_thr)) ? cfg.max_thr
                                                      : th_raw[aarf_pkg::THR_W-1:0];
  assign tl_raw = prod2_r[PROD_W-1:4];

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_r     <= in_command;
      idx_r     <= wrap_tab[in_station];
      ok_r      <= in_success;
      retries_r <= in_retry_count;
    end
    if (cmd.read) begin
      rd_word_r <= mem[idx_r];
    end
    if (cmd.eval) begin
      new_r      <= !rd_word_r.valid;
      rem_zero_r <= (rem_calc(retries_r, spacing_c) == '0);
      if (rd_word_r.valid) begin
        e_r <= rd_word_r.e;
      end else begin
        e_r.rate  <= start_c;
        e_r.run   <= '0;
        e_r.timer <= '0;
        e_r.thr   <= cfg.init_thr;
        e_r.limit <= cfg.min_timer;
        e_r.probe <= 1'b0;
      end
    end
    if (cmd.mul1) begin
      prod1_r <= e_r.thr * cfg.thr_growth;
    end
    if (cmd.mul2) begin
      th_r    <= th_c;
      prod2_r <= cfg.tmr_growth * th_c;
    end
    if (cmd.update) begin
      res_e_r       <= n_e;
      res_changed_r <= n_changed;
    end
    if (cmd.load_out) begin
      out_rate_r    <= res_e_r.rate;
      out_changed_r <= res_changed_r;
      out_probe_r   <= res_e_r.probe;
    end
  end

  // Per-station update applied to the entry read in the earlier steps.
  always_comb begin
    logic [aarf_pkg::RATE_W-1:0]  up;
    logic [aarf_pkg::RATE_W-1:0]  down;
    logic [aarf_pkg::RUN_W-1:0]   run1;
    logic [aarf_pkg::TIMER_W-1:0] tmr1;
    n_e  = e_r;
    up   = (e_r.rate < top_c) ? e_r.rate + 1'b1 : e_r.rate;
    down = (e_r.rate != '0) ? e_r.rate - 1'b1 : e_r.rate;
    run1 = (e_r.run < e_r.thr) ? e_r.run + 1'b1 : e_r.run;
    tmr1 = (e_r.timer < e_r.limit) ? e_r.timer + 1'b1 : e_r.timer;
    if (cmd_r == aarf_pkg::CMD_REPORT) begin
      if (ok_r) begin
        if (((run1 >= e_r.thr) || (e_r.timer >= e_r.limit)) && (up != e_r.rate)) begin
          n_e.rate  = up;
          n_e.timer = '0;
          n_e.run   = '0;
          n_e.probe = 1'b1;
        end else begin
          n_e.timer = tmr1;
          n_e.run   = run1;
          n_e.probe = 1'b0;
        end
      end else begin
        n_e.run = '0;
        if (e_r.probe) begin
          n_e.timer = '0;
          if (retries_r == aarf_pkg::RETRY_W'(1)) begin
            n_e.thr   = th_r;
            n_e.limit = (tl_raw < cfg.min_timer) ? cfg.min_timer : tl_raw;
            n_e.rate  = down;
          end
        end else begin
          if (rem_zero_r) begin
            n_e.thr   = cfg.init_thr;
            n_e.limit = cfg.min_timer;
            n_e.rate  = down;
          end
          n_e.timer = (retries_r >= spacing_c) ? '0 : tmr1;
        end
      end
    end
    n_changed = new_r || (n_e.rate != e_r.rate);
  end

  always_comb begin
    wr_word.valid = !cmd.clear;
    wr_word.e     = n_e;
  end

  // Single write port shared by the clearing sweep and the write-back.
  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      mem[clr_addr] <= wr_word;
    end else if (cmd.update) begin
      mem[idx_r] <= wr_word;
    end
  end

  assign out_rate         = out_rate_r;
  assign out_rate_changed = out_changed_r;
  assign out_probing      = out_probe_r;

endmodule

[rtl/core/aarf_rate_adaptation.sv]
// AARF transmit rate adaptation for up to STATIONS stations. Each input word
// names a station and either asks for its current rate index or reports one
// transmitted frame (acknowledged or not, with its retry count); every input
// word yields exactly one result word with the station's rate index, a flag
// that the rate changed or the station was first seen, and its probing flag.
// An item passes through the read-modify-write of the single-port station
// table (read, evaluate and write-back steps), the two registered
// multiplies of the threshold back-off and the hand-off to the output
// register, and only then does the block return to idle and accept the
// next item. A waiting result sits in an output register, so the next
// item is accepted and worked on before it is taken, stalling only in its
// final step. After reset the block sweeps the station table one entry at
// a time to mark every entry unused, and accepts no item during that time;
// configuration writes are taken throughout. Configure the registers over
// the APB port only while no item is in flight.
module aarf_rate_adaptation #(
  parameter int STATIONS   = 64,
  parameter int RATE_COUNT = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Input words.
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_command,
  input  logic [aarf_pkg::STATION_W-1:0]      in_station,
  input  logic                                in_success,
  input  logic [aarf_pkg::RETRY_W-1:0]        in_retry_count,
  // Result words.
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [aarf_pkg::RATE_W-1:0]         out_rate,
  output logic                                out_rate_changed,
  output logic                                out_probing,
  // Configuration registers.
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [aarf_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [aarf_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [aarf_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                pready
);

  // The table index needs at least one bit even for a single station.
  localparam int IDX_W = (STATIONS > 1) ? $clog2(STATIONS) : 1;

  aarf_pkg::cfg_t   cfg;
  aarf_pkg::cmd_t   cmd;
  logic [IDX_W-1:0] clr_addr;

  aarf_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // The controller sequences each item through read, evaluate, the two
  // multiply steps, write-back and hand-off to the output register.
  aarf_ctrl #(
    .STATIONS (STATIONS),
    .IDX_W    (IDX_W)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .clr_addr  (clr_addr)
  );

  // The datapath holds the station table, the per-item working registers and
  // the output register.
  aarf_dp #(
    .STATIONS   (STATIONS),
    .RATE_COUNT (RATE_COUNT),
    .IDX_W      (IDX_W)
  ) u_dp (
    .clk              (clk),
    .cmd              (cmd),
    .clr_addr         (clr_addr),
    .cfg              (cfg),
    .in_command       (in_command),
    .in_station       (in_station),
    .in_success       (in_success),
    .in_retry_count   (in_retry_count),
    .out_rate         (out_rate),
    .out_rate_changed (out_rate_changed),
    .out_probing      (out_probing)
  );

endmodule

[rtl/core/aarf_checker.sv]
module aarf_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [aarf_pkg::RATE_W-1:0]     out_rate,
  input logic                            out_rate_changed,
  input logic                            out_probing,
  input logic                            pready
);

  // A result that is not taken holds its word.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_rate) &&
      $stable(out_rate_changed) && $stable(out_probing))
    else $error("result word changed while stalled");

  // Coming out of reset the table sweep blocks input and no result is offered.
  a_reset_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !in_ready && !out_valid)
    else $error("block active right after reset");

  // One item at a time: after an acceptance the input closes.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while an item is in flight");

  // Guards against a fresh result appearing too early after an acceptance.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |-> ##1 !$rose(out_valid) ##1 !$rose(out_valid))
    else $error("result appeared too early");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
    else $error("pready dropped");

endmodule

bind aarf_rate_adaptation aarf_checker u_aarf_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_rate         (out_rate),
  .out_rate_changed (out_rate_changed),
  .out_probing      (out_probing),
  .pready           (pready)
);

[verif/aarf_rate_adaptation_tb.sv]
module aarf_rate_adaptation_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import aarf_pkg::*;

  localparam int STATIONS     = 64;
  localparam int RATE_COUNT   = 16;
  localparam int HOT_STATIONS = 6;
  localparam int PHASE_WORDS  = 120;
  localparam int LONG_HOLD    = 400;

  // One input word and one result word, at the widths of the ports.
  typedef struct packed {
    logic                 command;
    logic [STATION_W-1:0] station;
    logic                 success;
    logic [RETRY_W-1:0]   retry_count;
  } station_word_t;

  typedef struct packed {
    logic [RATE_W-1:0] rate;
    logic              rate_changed;
    logic              probing;
  } rate_word_t;

  typedef enum logic [1:0] {RX_FREE, RX_PATTERN, RX_RANDOM} rx_mode_t;

  logic                  clk              = 1'b0;
  logic                  rst_n            = 1'b0;
  logic                  in_valid         = 1'b0;
  logic                  in_ready;
  logic                  in_command       = CMD_QUERY;
  logic [STATION_W-1:0]  in_station       = '0;
  logic                  in_success       = 1'b0;
  logic [RETRY_W-1:0]    in_retry_count   = '0;
  logic                  out_valid;
  logic                  out_ready        = 1'b0;
  logic [RATE_W-1:0]     out_rate;
  logic                  out_rate_changed;
  logic                  out_probing;
  logic                  psel             = 1'b0;
  logic                  penable          = 1'b0;
  logic                  pwrite           = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr            = '0;
  logic [CFG_DATA_W-1:0] pwdata           = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  // Words waiting to be offered, and the results the predictor expects, oldest first.
  station_word_t report_q[$];
  rate_word_t    rate_expect_q[$];
  int unsigned   mismatch_count = 0;

  // Request from the stimulus for one long stall of the receiver (rising edge starts it).
  logic rx_long_hold_go = 1'b0;

  // Stations that carry most of the traffic in the current phase.
  logic [STATION_W-1:0] hot_station [HOT_STATIONS];

  // Predictor copy of the configuration registers and of the station table.
  cfg_t              cfg_shadow = CFG_RESET;
  logic              st_valid [STATIONS] = '{default: 1'b0};
  logic [RATE_W-1:0] st_rate  [STATIONS];
  logic [RUN_W-1:0]  st_run   [STATIONS];
  logic [TIMER_W-1:0] st_timer [STATIONS];
  logic [THR_W-1:0]  st_thr   [STATIONS];
  logic [TIMER_W-1:0] st_limit [STATIONS];
  logic              st_probe [STATIONS];

  aarf_rate_adaptation #(
    .STATIONS  (STATIONS),
    .RATE_COUNT(RATE_COUNT)
  ) i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_command      (in_command),
    .in_station      (in_station),
    .in_success      (in_success),
    .in_retry_count  (in_retry_count),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_rate        (out_rate),
    .out_rate_changed(out_rate_changed),
    .out_probing     (out_probing),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always #2 clk = ~clk;

  // A rate register may hold more than the rate table has; the block saturates it.
  function automatic int unsigned clamp_rate(input logic [RATE_W-1:0] r);
    return (32'(r) > RATE_COUNT - 1) ? RATE_COUNT - 1 : 32'(r);
  endfunction

  // Applies one input word to the predicted station table and returns the
  // result word it must produce. An unseen station is first set up from the
  // current configuration, which also counts as a rate change.
  function automatic rate_word_t adapt_station(input station_word_t w);
    int unsigned       s;
    int unsigned       up;
    int unsigned       spacing;
    int unsigned       th;
    int unsigned       tl;
    logic [RATE_W-1:0] prior;
    rate_word_t        res;
    s = 32'(w.station) % STATIONS;
    res.rate_changed = 1'b0;
    if (!st_valid[s]) begin
      st_valid[s] = 1'b1;
      st_rate[s]  = RATE_W'(clamp_rate(cfg_shadow.start_rate));
      st_run[s]   = '0;
      st_timer[s] = '0;
      st_thr[s]   = cfg_shadow.init_thr;
      st_limit[s] = cfg_shadow.min_timer;
      st_probe[s] = 1'b0;
      res.rate_changed = 1'b1;
    end
    prior = st_rate[s];
    if (w.command == CMD_REPORT) begin
      if (w.success) begin
        // Step up after a full run of successes or once the timer has run out,
        // unless the station already sits at the top rate.
        up = (32'(st_rate[s]) < clamp_rate(cfg_shadow.top_rate)) ?
             32'(st_rate[s]) + 1 : 32'(st_rate[s]);
        if (st_run[s] < st_thr[s]) st_run[s] = st_run[s] + 1'b1;
        if ((st_run[s] >= st_thr[s] || st_timer[s] >= st_limit[s]) &&
            up != 32'(st_rate[s])) begin
          st_rate[s]  = RATE_W'(up);
          st_timer[s] = '0;
          st_run[s]   = '0;
          st_probe[s] = 1'b1;
        end else begin
          if (st_timer[s] < st_limit[s]) st_timer[s] = st_timer[s] + 1'b1;
          st_probe[s] = 1'b0;
        end
      end else begin
        spacing = (cfg_shadow.spacing == '0) ? 1 : 32'(cfg_shadow.spacing);
        if (st_timer[s] < st_limit[s]) st_timer[s] = st_timer[s] + 1'b1;
        st_run[s] = '0;
        if (st_probe[s]) begin
          // A probe that failed on its first try backs off: the threshold
          // grows by the Q4.4 factor up to its cap and the timer limit follows.
          st_timer[s] = '0;
          if (w.retry_count == 1) begin
            th = (32'(st_thr[s]) * 32'(cfg_shadow.thr_growth)) >> 4;
            if (th > 32'(cfg_shadow.max_thr)) th = 32'(cfg_shadow.max_thr);
            st_thr[s] = THR_W'(th);
            tl = (32'(cfg_shadow.tmr_growth) * th) >> 4;
            if (tl < 32'(cfg_shadow.min_timer)) tl = 32'(cfg_shadow.min_timer);
            st_limit[s] = TIMER_W'(tl);
            if (st_rate[s] != '0) st_rate[s] = st_rate[s] - 1'b1;
          end
        end else begin
          // Outside a probe, a retry count on the spacing grid (zero included)
          // drops one rate and restores both thresholds.
          if (32'(w.retry_count) % spacing == 0) begin
            st_thr[s]   = cfg_shadow.init_thr;
            st_limit[s] = cfg_shadow.min_timer;
            if (st_rate[s] != '0) st_rate[s] = st_rate[s] - 1'b1;
          end
          if (32'(w.retry_count) >= spacing) st_timer[s] = '0;
        end
      end
    end
    if (st_rate[s] != prior) res.rate_changed = 1'b1;
    res.rate    = st_rate[s];
    res.probing = st_probe[s];
    return res;
  endfunction

  // Mostly reports on the hot stations, with acknowledged frames dominant so
  // that rates climb and probes happen; failures favor a single retry, which
  // is the case that ends a probe. One word in sixteen is unconstrained noise.
  function automatic station_word_t random_word();
    station_word_t w;
    int unsigned   pick;
    pick = $urandom_range(0, 15);
    w.station = hot_station[$urandom_range(0, HOT_STATIONS - 1)];
    w.command = (pick == 0) ? CMD_QUERY : CMD_REPORT;
    w.success = ($urandom_range(0, 3) != 0);
    if (w.success) begin
      w.retry_count = $urandom_range(0, 1) ? '0 : RETRY_W'($urandom_range(0, 15));
    end else begin
      case ($urandom_range(0, 3))
        0, 1:    w.retry_count = RETRY_W'(1);
        2:       w.retry_count = RETRY_W'($urandom_range(2, 4));
        default: w.retry_count = RETRY_W'($urandom_range(0, 15));
      endcase
    end
    if (pick == 15) begin
      w.command     = $urandom_range(0, 1) ? CMD_REPORT : CMD_QUERY;
      w.station     = STATION_W'($urandom_range(0, 63));
      w.success     = 1'($urandom_range(0, 1));
      w.retry_count = RETRY_W'($urandom_range(0, 15));
    end
    return w;
  endfunction

  // Sender: offers words from report_q in bursts of random length with random
  // gaps, some of them zero so that back-to-back stretches also occur. A word
  // stays on the port unchanged until the block takes it.
  always @(posedge clk) begin : sender
    station_word_t next_word;
    int            burst_left;
    int            gap_left;
    if (!rst_n) begin
      in_valid   <= 1'b0;
      burst_left = 1;
      gap_left   = 0;
    end else if (!in_valid || in_ready) begin
      if (gap_left > 0 || report_q.size() == 0) begin
        in_valid <= 1'b0;
        if (gap_left > 0) gap_left = gap_left - 1;
      end else begin
        next_word = report_q.pop_front();
        in_valid       <= 1'b1;
        in_command     <= next_word.command;
        in_station     <= next_word.station;
        in_success     <= next_word.success;
        in_retry_count <= next_word.retry_count;
        burst_left = burst_left - 1;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 16);
          case ($urandom_range(0, 7))
            0, 1, 2: gap_left = 0;
            7:       gap_left = $urandom_range(10, 30);
            default: gap_left = $urandom_range(1, 6);
          endcase
        end
      end
    end
  end

  // Receiver: when its tick counter wraps it picks free running, a random ready
  // pattern, or draws high two times in three. A request from the stimulus starts
  // one long stall, counted here, that lets the block fill up and push back on input.
  always @(posedge clk) begin : receiver
    rx_mode_t    mode;
    logic [15:0] pattern;
    logic [5:0]  tick;
    logic        go_seen;
    int          hold_left;
    if (!rst_n) begin
      out_ready <= 1'b0;
      mode      = RX_FREE;
      pattern   = 16'hFFFF;
      tick      = '0;
      go_seen   = 1'b0;
      hold_left = 0;
    end else begin
      if (rx_long_hold_go && !go_seen) hold_left = LONG_HOLD;
      go_seen = rx_long_hold_go;
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        out_ready <= 1'b0;
      end else begin
        tick = tick + 1'b1;
        if (tick == '0) begin
          mode    = rx_mode_t'($urandom_range(0, 2));
          pattern = 16'($urandom()) | 16'h0001;
        end
        case (mode)
          RX_FREE:    out_ready <= 1'b1;
          RX_PATTERN: out_ready <= pattern[tick[3:0]];
          default:    out_ready <= ($urandom_range(0, 2) != 0);
        endcase
      end
    end
  end

  // Every accepted input word is run through the predictor; every accepted
  // result word is checked against the oldest prediction.
  always @(posedge clk) begin : scoreboard
    rate_word_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (rate_expect_q.size() == 0) begin
          $error("result word with none expected: rate %0d changed %0b probing %0b",
                 out_rate, out_rate_changed, out_probing);
          mismatch_count++;
        end else begin
          want = rate_expect_q.pop_front();
          if (out_rate !== want.rate) begin
            $error("rate: expected %0d, got %0d", want.rate, out_rate);
            mismatch_count++;
          end
          if (out_rate_changed !== want.rate_changed) begin
            $error("rate_changed: expected %0b, got %0b", want.rate_changed,
                   out_rate_changed);
            mismatch_count++;
          end
          if (out_probing !== want.probing) begin
            $error("probing: expected %0b, got %0b", want.probing, out_probing);
            mismatch_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        rate_expect_q.push_back(adapt_station('{command:     in_command,
                                                station:     in_station,
                                                success:     in_success,
                                                retry_count: in_retry_count}));
      end
    end
  end

  // One APB transfer. The read data is taken in the access phase once pready
  // is seen, and the transfer completes at the following rising edge.
  task automatic apb_cycle(input logic wr, input cfg_idx_t idx,
                           input logic [CFG_DATA_W-1:0] wdata,
                           output logic [CFG_DATA_W-1:0] rdata);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    while (!pready) begin
      @(posedge clk);
      @(negedge clk);
    end
    rdata = prdata;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Writes a register, mirrors it into the predictor and reads it back.
  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
    logic [CFG_DATA_W-1:0] back;
    apb_cycle(1'b1, idx, value, back);
    case (idx)
      CFG_INIT_THR:   cfg_shadow.init_thr   = value[THR_W-1:0];
      CFG_MAX_THR:    cfg_shadow.max_thr    = value[THR_W-1:0];
      CFG_SPACING:    cfg_shadow.spacing    = value[RETRY_W-1:0];
      CFG_MIN_TIMER:  cfg_shadow.min_timer  = value[TIMER_W-1:0];
      CFG_THR_GROWTH: cfg_shadow.thr_growth = value[GROWTH_W-1:0];
      CFG_TMR_GROWTH: cfg_shadow.tmr_growth = value[GROWTH_W-1:0];
      CFG_START_RATE: cfg_shadow.start_rate = value[RATE_W-1:0];
      default:        cfg_shadow.top_rate   = value[RATE_W-1:0];
    endcase
    apb_cycle(1'b0, idx, '0, back);
    if (back !== value) begin
      $error("%s: expected %0d, got %0d", idx.name(), value, back);
      mismatch_count++;
    end
  endtask

  task automatic load_settings(input cfg_t c);
    write_reg(CFG_INIT_THR,   CFG_DATA_W'(c.init_thr));
    write_reg(CFG_MAX_THR,    CFG_DATA_W'(c.max_thr));
    write_reg(CFG_SPACING,    CFG_DATA_W'(c.spacing));
    write_reg(CFG_MIN_TIMER,  CFG_DATA_W'(c.min_timer));
    write_reg(CFG_THR_GROWTH, CFG_DATA_W'(c.thr_growth));
    write_reg(CFG_TMR_GROWTH, CFG_DATA_W'(c.tmr_growth));
    write_reg(CFG_START_RATE, CFG_DATA_W'(c.start_rate));
    write_reg(CFG_TOP_RATE,   CFG_DATA_W'(c.top_rate));
  endtask

  // Waits until every queued word has been taken and every result has
  // arrived, then lets the block settle. Sampling on the falling edge keeps
  // clear of the updates made at the rising edge.
  task automatic wait_drained();
    do @(negedge clk);
    while (report_q.size() != 0 || in_valid || rate_expect_q.size() != 0);
    repeat (10) @(posedge clk);
  endtask

  task automatic queue_word(input logic cmd, input int unsigned station,
                            input logic ok, input int unsigned retries);
    report_q.push_back('{command: cmd, station: STATION_W'(station), success: ok,
                         retry_count: RETRY_W'(retries)});
  endtask

  initial begin : stimulus
    cfg_t c;
    int   words;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, with the reset configuration. Station creation on a
    // query and on a report, a repeated query that changes nothing, a failure
    // with zero retries, a run of successes that steps up and starts a probe,
    // a probe that fails on its first retry and backs off, a failure on the
    // retry grid outside a probe, and the extremes of every field.
    @(negedge clk);
    queue_word(CMD_QUERY,  0,  1'b0, 0);
    queue_word(CMD_QUERY,  0,  1'b1, 15);
    queue_word(CMD_REPORT, 63, 1'b1, 15);
    queue_word(CMD_REPORT, 42, 1'b0, 0);
    queue_word(CMD_REPORT, 42, 1'b0, 3);
    repeat (10) queue_word(CMD_REPORT, 1, 1'b1, 0);
    queue_word(CMD_REPORT, 1,  1'b0, 1);
    queue_word(CMD_REPORT, 1,  1'b0, 2);
    queue_word(CMD_QUERY,  1,  1'b0, 0);
    queue_word(CMD_REPORT, 1,  1'b1, 10);
    queue_word(CMD_REPORT, 1,  1'b0, 2);
    queue_word(CMD_REPORT, 21, 1'b1, 5);
    queue_word(CMD_REPORT, 21, 1'b0, 15);
    queue_word(CMD_QUERY,  63, 1'b0, 0);
    wait_drained();

    // Random phases. The first two use corner settings: lowest thresholds with
    // a zero retry spacing, then highest values with the start rate above the
    // top rate. The rest draw settings that keep thresholds small enough for
    // rates to climb, time out and back off often.
    for (int ph = 1; ph <= 7; ph++) begin
      case (ph)
        1: c = '{init_thr: 8'd1, max_thr: 8'd1, spacing: 4'd0, min_timer: 12'd1,
                 thr_growth: 8'd16, tmr_growth: 8'd16, start_rate: 4'd0,
                 top_rate: 4'd15};
        2: c = '{init_thr: 8'd255, max_thr: 8'd255, spacing: 4'd15,
                 min_timer: 12'd4095, thr_growth: 8'd255, tmr_growth: 8'd255,
                 start_rate: 4'd15, top_rate: 4'd0};
        default: begin
          c.init_thr   = THR_W'($urandom_range(1, 24));
          c.max_thr    = $urandom_range(0, 1) ? THR_W'($urandom_range(c.init_thr, 90))
                                              : THR_W'($urandom_range(1, 255));
          c.spacing    = RETRY_W'($urandom_range(0, 15));
          c.min_timer  = TIMER_W'($urandom_range(1, 40));
          c.thr_growth = GROWTH_W'($urandom_range(16, 255));
          c.tmr_growth = GROWTH_W'($urandom_range(16, 255));
          c.start_rate = RATE_W'($urandom_range(0, 4));
          c.top_rate   = $urandom_range(0, 2) ? RATE_W'($urandom_range(0, 15)) : 4'd15;
        end
      endcase
      load_settings(c);
      foreach (hot_station[k]) hot_station[k] = STATION_W'($urandom_range(0, 63));

      // One phase starts with a long receiver stall while words keep coming.
      if (ph == 3) begin
        @(posedge clk);
        rx_long_hold_go <= 1'b1;
      end

      @(negedge clk);
      words = (ph == 4) ? PHASE_WORDS / 2 : PHASE_WORDS;
      repeat (words) report_q.push_back(random_word());

      // In another phase the sender stops halfway until every result is in.
      if (ph == 4) begin
        wait_drained();
        @(negedge clk);
        repeat (PHASE_WORDS - words) report_q.push_back(random_word());
      end

      wait_drained();
      if (ph == 3) begin
        @(posedge clk);
        rx_long_hold_go <= 1'b0;
      end
    end

    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && rate_expect_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Ends the run with an error if the stimulus does not finish first.
  initial begin : watchdog
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
